FILE: sv/cap_pkg.sv
// ----------------------------------------------------------------------------
// cap_pkg - shared types and constants of the comb/allpass reverb
// Sample and coefficient types, register codes, sequencer states, the
// multiply-accumulate command and the output saturation function.
// ----------------------------------------------------------------------------
`default_nettype none

package cap_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Position counters cover the largest line lengths allowed
    localparam int COMB_PW = 11;
    localparam int AP_PW   = 10;
    localparam int NUM_COMB = 4;
    localparam int NUM_AP   = 2;

    // Multiply-accumulate datapath
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 18;
    localparam int BIAS_W  = 25;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = 44;
    localparam int SUM_W   = 26;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [COEF_W-1:0]          t_coef;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic signed [MUL_B_W-1:0] Q16_ONE  = 18'sd65536;
    localparam logic signed [MUL_B_W-1:0] Q16_HALF = 18'sd32768;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_GAIN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_COEFF = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX    = 8'd3;

    // Register reset values
    localparam logic  RST_ENABLE     = 1'b1;
    localparam t_coef RST_ROOM_GAIN  = 16'd45875;
    localparam t_coef RST_DAMP_COEFF = 16'd22938;
    localparam t_coef RST_WET_MIX    = 16'd19661;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PASS,
        ST_C_RD,
        ST_C_MUL0,
        ST_C_MUL1,
        ST_C_DAMP,
        ST_C_FB,
        ST_C_WR,
        ST_SUM,
        ST_A_RD,
        ST_A_MUL0,
        ST_A_WR,
        ST_A_OUT,
        ST_M_MUL0,
        ST_M_MUL1,
        ST_DONE
    } t_state;

    // One command to the shared multiply-accumulate unit.
    // load: acc = bias * 2^16 + 2^15 + ma * mb, else acc = acc + ma * mb.
    typedef struct packed {
        logic                        en;
        logic                        load;
        logic signed [BIAS_W-1:0]    bias;
        logic signed [MUL_A_W-1:0]   ma;
        logic signed [MUL_B_W-1:0]   mb;
    } t_mac_op;

    // Clamp the integer part of the accumulator to the sample range
    function automatic t_sample f_sat(input logic signed [ACC_W-FRAC_W-1:0] v);
        logic [ACC_W-FRAC_W-SAMPLE_W:0] top;
        top = v[ACC_W-FRAC_W-1:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            f_sat = t_sample'(v[SAMPLE_W-1:0]);
        end else if (v[ACC_W-FRAC_W-1]) begin
            f_sat = SAMPLE_MIN;
        end else begin
            f_sat = SAMPLE_MAX;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/cap_if.sv
// ----------------------------------------------------------------------------
// cap_if - channel interfaces of the comb/allpass reverb
// Input sample stream, output sample stream and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cap_in_if;
    import cap_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface cap_out_if;
    import cap_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface cap_cfg_if;
    import cap_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/cap_ram.sv
// ----------------------------------------------------------------------------
// cap_ram - single-port delay line store
// One address per cycle, write or registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/cap_mac.sv
// ----------------------------------------------------------------------------
// cap_mac - shared multiply-accumulate unit
// Signed 24x18 multiplier with a 44-bit accumulator, rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_mac (
    input  logic             i_clk,
    input  cap_pkg::t_mac_op i_op,
    output cap_pkg::t_sample o_result
);
    import cap_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

    logic signed [MUL_A_W+MUL_B_W-1:0] w_prod;
    logic signed [ACC_W-1:0]           w_base;
    logic signed [ACC_W-1:0]           n_acc;
    logic signed [ACC_W-1:0]           r_acc;

    always_comb begin
        w_prod = i_op.ma * i_op.mb;
        if (i_op.load) begin
            w_base = (ACC_W'(i_op.bias) <<< FRAC_W) + RND_HALF;
        end else begin
            w_base = r_acc;
        end
        n_acc = w_base + ACC_W'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= n_acc;
        end
    end

    // Floor shift of the biased sum gives round half up
    assign o_result = f_sat(r_acc[ACC_W-1:FRAC_W]);

endmodule

`default_nettype wire

FILE: sv/comb_allpass_reverb.sv
// ----------------------------------------------------------------------------
// comb_allpass_reverb - four damped combs and two allpass stages
// Sequenced reverb datapath around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Output: registered; loaded after the full sequence when enabled, after the
//   pass-through state when disabled; a stalled output adds its stall.
// Input: one sample at a time, taken only in idle after the last result is
//   loaded; set by the sequencer stepping every multiply through the single MAC unit.
// Reset: synchronous, active low. After reset both delay stores are zeroed,
//   one address a cycle, through the larger of the two stores; no input
//   transaction is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module comb_allpass_reverb #(
    parameter int COMB_LEN_A    = 1116,
    parameter int COMB_LEN_B    = 1188,
    parameter int COMB_LEN_C    = 1277,
    parameter int COMB_LEN_D    = 1356,
    parameter int ALLPASS_LEN_A = 556,
    parameter int ALLPASS_LEN_B = 441
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cap_in_if.sink      i_in,
    cap_out_if.source   o_out,
    cap_cfg_if.sink     i_cfg
);
    import cap_pkg::*;

    // ------------------------------------------------------------------
    // Store geometry: the four comb lines share one store back to back,
    // the two allpass lines another.
    // ------------------------------------------------------------------
    localparam int COMB_TOTAL = COMB_LEN_A + COMB_LEN_B + COMB_LEN_C + COMB_LEN_D;
    localparam int AP_TOTAL   = ALLPASS_LEN_A + ALLPASS_LEN_B;
    localparam int COMB_AW    = $clog2(COMB_TOTAL);
    localparam int AP_AW      = $clog2(AP_TOTAL);
    localparam int CLR_LEN    = (COMB_TOTAL > AP_TOTAL) ? COMB_TOTAL : AP_TOTAL;
    localparam int CLR_W      = $clog2(CLR_LEN);

    localparam logic [CLR_W-1:0] CLR_LAST     = CLR_W'(CLR_LEN - 1);
    localparam logic [CLR_W-1:0] CLR_COMB_END = CLR_W'(COMB_TOTAL - 1);
    localparam logic [CLR_W-1:0] CLR_AP_END   = CLR_W'(AP_TOTAL - 1);

    localparam logic [1:0] LAST_COMB = 2'(NUM_COMB - 1);
    localparam logic       LAST_AP   = 1'(NUM_AP - 1);

    localparam logic [COMB_PW-1:0] COMB_LEN [NUM_COMB] = '{
        COMB_PW'(COMB_LEN_A), COMB_PW'(COMB_LEN_B),
        COMB_PW'(COMB_LEN_C), COMB_PW'(COMB_LEN_D)};
    localparam logic [COMB_AW-1:0] COMB_BASE [NUM_COMB] = '{
        COMB_AW'(0), COMB_AW'(COMB_LEN_A), COMB_AW'(COMB_LEN_A + COMB_LEN_B),
        COMB_AW'(COMB_LEN_A + COMB_LEN_B + COMB_LEN_C)};
    localparam logic [AP_PW-1:0] AP_LEN [NUM_AP] = '{
        AP_PW'(ALLPASS_LEN_A), AP_PW'(ALLPASS_LEN_B)};
    localparam logic [AP_AW-1:0] AP_BASE [NUM_AP] = '{
        AP_AW'(0), AP_AW'(ALLPASS_LEN_A)};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CLR_W-1:0]   r_clr;

    logic               r_enable;
    t_coef              r_room_gain;
    t_coef              r_damp_coeff;
    t_coef              r_wet_mix;

    logic [COMB_PW-1:0] r_comb_pos [NUM_COMB];
    logic [AP_PW-1:0]   r_ap_pos   [NUM_AP];
    t_sample            r_damp_st  [NUM_COMB];
    logic [1:0]         r_k;
    logic               r_j;

    t_sample            r_x;
    t_sample            r_a;
    logic signed [SUM_W-1:0] r_sum;

    logic               r_out_valid;
    t_sample            r_out_sample;

    // ------------------------------------------------------------------
    // Datapath wiring
    // ------------------------------------------------------------------
    t_mac_op            w_op;
    t_sample            w_mac;

    logic               w_comb_en, w_comb_we;
    logic [COMB_AW-1:0] w_comb_addr;
    t_sample            w_comb_wdata;
    logic [SAMPLE_W-1:0] w_comb_rdata;
    t_sample            w_comb_rd;

    logic               w_ap_en, w_ap_we;
    logic [AP_AW-1:0]   w_ap_addr;
    t_sample            w_ap_wdata;
    logic [SAMPLE_W-1:0] w_ap_rdata;
    t_sample            w_ap_rd;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_load_out;
    logic signed [SUM_W-1:0] w_sum_p2;
    logic signed [MUL_B_W-1:0] w_one_minus_d;
    logic signed [MUL_B_W-1:0] w_one_minus_w;
    logic [COMB_PW-1:0] w_comb_pos_inc;
    logic [AP_PW-1:0]   w_ap_pos_inc;

    assign w_comb_rd = t_sample'(w_comb_rdata);
    assign w_ap_rd   = t_sample'(w_ap_rdata);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Output register parts the sequencer from the downstream stall
    assign w_out_free       = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;

    assign w_one_minus_d = Q16_ONE - $signed(MUL_B_W'(r_damp_coeff));
    assign w_one_minus_w = Q16_ONE - $signed(MUL_B_W'(r_wet_mix));

    // Comb sum scaled by a quarter with round half up; always in range
    assign w_sum_p2 = r_sum + SUM_W'(2);

    assign w_comb_pos_inc = COMB_PW'(r_comb_pos[r_k] + 1'b1);
    assign w_ap_pos_inc   = AP_PW'(r_ap_pos[r_j] + 1'b1);

    // ------------------------------------------------------------------
    // Shared arithmetic unit and delay stores
    // ------------------------------------------------------------------
    cap_mac u_mac (
        .i_clk    (i_clk),
        .i_op     (w_op),
        .o_result (w_mac)
    );

    cap_ram #(
        .DEPTH (COMB_TOTAL),
        .WIDTH (SAMPLE_W)
    ) u_comb_ram (
        .i_clk   (i_clk),
        .i_en    (w_comb_en),
        .i_we    (w_comb_we),
        .i_addr  (w_comb_addr),
        .i_wdata (w_comb_wdata),
        .o_rdata (w_comb_rdata)
    );

    cap_ram #(
        .DEPTH (AP_TOTAL),
        .WIDTH (SAMPLE_W)
    ) u_ap_ram (
        .i_clk   (i_clk),
        .i_en    (w_ap_en),
        .i_we    (w_ap_we),
        .i_addr  (w_ap_addr),
        .i_wdata (w_ap_wdata),
        .o_rdata (w_ap_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // Per comb: read, two products into the lowpass, save it, feedback
    // product plus input, write back. Then the quarter-scaled sum, per
    // allpass: read, write-back product, output difference. Then the mix.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == CLR_LAST) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_enable ? ST_C_RD : ST_PASS;
                end
            end
            ST_PASS:   if (w_out_free) n_state = ST_IDLE;
            ST_C_RD:   n_state = ST_C_MUL0;
            ST_C_MUL0: n_state = ST_C_MUL1;
            ST_C_MUL1: n_state = ST_C_DAMP;
            ST_C_DAMP: n_state = ST_C_FB;
            ST_C_FB:   n_state = ST_C_WR;
            ST_C_WR:   n_state = (r_k == LAST_COMB) ? ST_SUM : ST_C_RD;
            ST_SUM:    n_state = ST_A_RD;
            ST_A_RD:   n_state = ST_A_MUL0;
            ST_A_MUL0: n_state = ST_A_WR;
            ST_A_WR:   n_state = ST_A_OUT;
            ST_A_OUT:  n_state = (r_j == LAST_AP) ? ST_M_MUL0 : ST_A_RD;
            ST_M_MUL0: n_state = ST_M_MUL1;
            ST_M_MUL1: n_state = ST_DONE;
            ST_DONE:   if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (MAC command, store controls, output load)
    // ------------------------------------------------------------------
    always_comb begin
        w_op = '0;
        unique case (r_state)
            ST_C_MUL0: begin
                // o * (1 - d)
                w_op.en   = 1'b1;
                w_op.load = 1'b1;
                w_op.ma   = w_comb_rd;
                w_op.mb   = w_one_minus_d;
            end
            ST_C_MUL1: begin
                // + f * d
                w_op.en = 1'b1;
                w_op.ma = r_damp_st[r_k];
                w_op.mb = $signed(MUL_B_W'(r_damp_coeff));
            end
            ST_C_FB: begin
                // x + f * room
                w_op.en   = 1'b1;
                w_op.load = 1'b1;
                w_op.bias = BIAS_W'(r_x);
                w_op.ma   = r_damp_st[r_k];
                w_op.mb   = $signed(MUL_B_W'(r_room_gain));
            end
            ST_A_MUL0: begin
                // a + b / 2
                w_op.en   = 1'b1;
                w_op.load = 1'b1;
                w_op.bias = BIAS_W'(r_a);
                w_op.ma   = w_ap_rd;
                w_op.mb   = Q16_HALF;
            end
            ST_A_WR: begin
                // b - a
                w_op.en   = 1'b1;
                w_op.load = 1'b1;
                w_op.bias = -BIAS_W'(r_a);
                w_op.ma   = w_ap_rd;
                w_op.mb   = Q16_ONE;
            end
            ST_M_MUL0: begin
                // x * (1 - w)
                w_op.en   = 1'b1;
                w_op.load = 1'b1;
                w_op.ma   = r_x;
                w_op.mb   = w_one_minus_w;
            end
            ST_M_MUL1: begin
                // + y * w
                w_op.en = 1'b1;
                w_op.ma = r_a;
                w_op.mb = $signed(MUL_B_W'(r_wet_mix));
            end
            default: w_op = '0;
        endcase
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_comb_en    = 1'b0;
            w_comb_we    = (r_clr <= CLR_COMB_END);
            w_comb_addr  = r_clr[COMB_AW-1:0];
            w_comb_wdata = '0;
            w_ap_en      = 1'b0;
            w_ap_we      = (r_clr <= CLR_AP_END);
            w_ap_addr    = r_clr[AP_AW-1:0];
            w_ap_wdata   = '0;
        end else begin
            w_comb_en    = (r_state == ST_C_RD);
            w_comb_we    = (r_state == ST_C_WR);
            w_comb_addr  = COMB_BASE[r_k] + COMB_AW'(r_comb_pos[r_k]);
            w_comb_wdata = w_mac;
            w_ap_en      = (r_state == ST_A_RD);
            w_ap_we      = (r_state == ST_A_WR);
            w_ap_addr    = AP_BASE[r_j] + AP_AW'(r_ap_pos[r_j]);
            w_ap_wdata   = w_mac;
        end
    end

    assign w_load_out = ((r_state == ST_DONE) || (r_state == ST_PASS)) && w_out_free;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_enable     <= RST_ENABLE;
            r_room_gain  <= RST_ROOM_GAIN;
            r_damp_coeff <= RST_DAMP_COEFF;
            r_wet_mix    <= RST_WET_MIX;
            r_comb_pos   <= '{default: '0};
            r_ap_pos     <= '{default: '0};
            r_damp_st    <= '{default: '0};
            r_k          <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            // Register writes; unknown indexes drop
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ENABLE:     r_enable     <= i_cfg.data[0];
                    CFG_ROOM_GAIN:  r_room_gain  <= i_cfg.data;
                    CFG_DAMP_COEFF: r_damp_coeff <= i_cfg.data;
                    CFG_WET_MIX:    r_wet_mix    <= i_cfg.data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_k <= '0;
                        r_j <= '0;
                    end
                end
                ST_C_DAMP: r_damp_st[r_k] <= w_mac;
                ST_C_WR: begin
                    // Advance the comb tap, wrap at the line end
                    r_comb_pos[r_k] <= (w_comb_pos_inc >= COMB_LEN[r_k]) ? '0 : w_comb_pos_inc;
                    r_k             <= r_k + 1'b1;
                end
                ST_A_OUT: begin
                    r_ap_pos[r_j] <= (w_ap_pos_inc >= AP_LEN[r_j]) ? '0 : w_ap_pos_inc;
                    r_j           <= r_j + 1'b1;
                end
                default: ;
            endcase

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_x   <= i_in.sample_in;
                    r_sum <= '0;
                end
            end
            ST_C_MUL0: r_sum <= r_sum + SUM_W'(w_comb_rd);
            ST_SUM:    r_a   <= t_sample'(w_sum_p2[SUM_W-1:2]);
            ST_A_OUT:  r_a   <= w_mac;
            default: ;
        endcase

        if (w_load_out) begin
            r_out_sample <= (r_state == ST_PASS) ? r_x : w_mac;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cap_chk.sv
// ----------------------------------------------------------------------------
// cap_chk - port checker of the comb/allpass reverb
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cap_pkg::SAMPLE_W-1:0]   i_out_sample
);
    import cap_pkg::*;

    // Store clearing keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during store clearing");

    // One sample in flight: the input closes after each transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken twice in a row");

    // No result appears in the cycle right after an input transaction
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result earlier than the sequencer allows");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_sample)))
        else $error("stalled result changed");

endmodule

bind comb_allpass_reverb cap_chk u_cap_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out)
);

`default_nettype wire
